/* hdl/gray_sobel_edge_threshold_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the grey-scale Sobel edge unit
// Clocked on clk and disabled while rst_n is low at the point of use.
// ----------------------------------------------------------------------------
`ifndef GRAY_SOBEL_EDGE_THRESHOLD_UNIT_ASSERT_SVH
`define GRAY_SOBEL_EDGE_THRESHOLD_UNIT_ASSERT_SVH

// Same-cycle implication.
`define GSET_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define GSET_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/gset_pkg.sv */
// ----------------------------------------------------------------------------
// gset_pkg
// Shared widths, register indexes, constants and types of the grey-scale
// Sobel edge unit.
// ----------------------------------------------------------------------------
package gset_pkg;

    localparam int MAX_WIDTH_DEFAULT  = 1024;
    localparam int MAX_HEIGHT_DEFAULT = 1024;

    localparam int CMD_W     = 1;
    localparam int PIX_W     = 8;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_THRESHOLD = CFG_IDX_W'(2);

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET    = CFG_W'(1024);
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET   = CFG_W'(1024);
    localparam logic [CFG_W-1:0] EDGE_THRESHOLD_RESET = CFG_W'(200);

    localparam logic [CMD_W-1:0] CMD_PIXEL = CMD_W'(0);
    localparam logic [CMD_W-1:0] CMD_FLUSH = CMD_W'(1);

    localparam int GRAY_SUM_W  = 18;
    localparam int GRAY_PROD_W = 35;
    localparam int GRAY_SHIFT  = 26;
    localparam logic [GRAY_SUM_W-1:0] GRAY_WT_RED   = GRAY_SUM_W'(299);
    localparam logic [GRAY_SUM_W-1:0] GRAY_WT_GREEN = GRAY_SUM_W'(587);
    localparam logic [GRAY_SUM_W-1:0] GRAY_WT_BLUE  = GRAY_SUM_W'(114);
    localparam logic [GRAY_PROD_W-1:0] GRAY_RECIP   = GRAY_PROD_W'(67109);

    localparam int GRAD_W   = 10;
    localparam int SQ_W     = 20;
    localparam int MAG_W    = 21;
    localparam int THR_SQ_W = 22;

    localparam logic [PIX_W-1:0] EDGE_ON  = PIX_W'(255);
    localparam logic [PIX_W-1:0] EDGE_OFF = PIX_W'(0);

    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);
    localparam int INFLIGHT_W  = 3;

    typedef enum logic [1:0] {
        EMIT_NORMAL = 2'd0,
        EMIT_BORDER = 2'd1,
        EMIT_FINAL  = 2'd2
    } emit_mode_t;

    typedef struct packed {
        emit_mode_t mode;
        logic       left_centre;
        logic       right_centre;
        logic       top_centre;
        logic       bottom_centre;
        logic       last;
    } emit_info_t;

    function automatic logic [GRAY_SUM_W-1:0] gray_weighted_sum(
        input logic [PIX_W-1:0] red,
        input logic [PIX_W-1:0] green,
        input logic [PIX_W-1:0] blue
    );
        return GRAY_SUM_W'(red) * GRAY_WT_RED + GRAY_SUM_W'(green) * GRAY_WT_GREEN
             + GRAY_SUM_W'(blue) * GRAY_WT_BLUE;
    endfunction

endpackage

/* hdl/gset_ram.sv */
// ----------------------------------------------------------------------------
// gset_ram
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read. A read at the address being written returns the old data.
// ----------------------------------------------------------------------------
module gset_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* hdl/gray_sobel_edge_threshold_unit.sv */
// ----------------------------------------------------------------------------
// gray_sobel_edge_threshold_unit
// Grey conversion, 3x3 Sobel gradient with border replication and threshold
// on a raster-order RGB stream.
// ----------------------------------------------------------------------------
// Usage:
// While in_stall is low, input (in_valid) takes one word per clock: a pixel
// (cmd low) or a flush tick (cmd high). The output channel (out_valid /
// out_stall) gives one result word per output pixel, 255 for an edge, 0 else.
// Results trail the input by one row plus one pixel; after the last pixel of
// a frame, frame_width + 1 flush words drain the rest, and frame_last marks
// the final result. Results are registered on their way to the output buffer.
// One word is taken per unstalled clock; the line-store memory sets the rate,
// as it is read and written back once per word, with one-entry forwarding.
// Results queue in an 8-entry output buffer; in_stall rises only when the
// queued results plus those in the pipeline would fill it, so the input side
// keeps running while out_stall is held, until the buffer would be filled.
// Reset returns the registers to 1024 x 1024 with threshold 200, empties the
// pipeline and the buffer, and restarts at the first pixel of a frame. The
// line store needs no clearing. The user must write the registers through
// cfg_we / cfg_index / cfg_data only while idle; the unit does not enforce it.
// ----------------------------------------------------------------------------
`include "gray_sobel_edge_threshold_unit_assert.svh"

module gray_sobel_edge_threshold_unit #(
    parameter int MAX_WIDTH  = gset_pkg::MAX_WIDTH_DEFAULT,
    parameter int MAX_HEIGHT = gset_pkg::MAX_HEIGHT_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [gset_pkg::CMD_W-1:0]       cmd,
    input  logic [gset_pkg::PIX_W-1:0]       pixel_red,
    input  logic [gset_pkg::PIX_W-1:0]       pixel_green,
    input  logic [gset_pkg::PIX_W-1:0]       pixel_blue,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [gset_pkg::PIX_W-1:0]       edge_value,
    output logic                             frame_last,
    input  logic                             cfg_we,
    input  logic [gset_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gset_pkg::CFG_W-1:0]       cfg_data
);
    import gset_pkg::*;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WSZ_W  = $clog2(MAX_WIDTH + 1);
    localparam int HSZ_W  = $clog2(MAX_HEIGHT + 1);
    localparam int ROW_W  = $clog2(MAX_HEIGHT + 2);
    localparam int WCMP_W = (WSZ_W > CFG_W) ? WSZ_W : CFG_W;
    localparam int HCMP_W = (HSZ_W > CFG_W) ? HSZ_W : CFG_W;
    localparam int RAM_W  = 2 * PIX_W;
    localparam int STALL_W = FIFO_CNT_W + 1;

    // Configuration registers
    logic [CFG_W-1:0] frame_width_reg;
    logic [CFG_W-1:0] frame_height_reg;
    logic [CFG_W-1:0] edge_threshold_reg;
    logic [THR_SQ_W-1:0] thr_sq_reg;

    // Position counters
    logic [COL_W-1:0] in_column_reg, in_column_next;
    logic [ROW_W-1:0] in_row_reg, in_row_next;
    logic [COL_W-1:0] out_column_reg, out_column_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;

    // Sizes in use
    logic [WCMP_W-1:0] fw_ext;
    logic [HCMP_W-1:0] fh_ext;
    logic [WSZ_W-1:0]  w_size;
    logic [HSZ_W-1:0]  h_size;
    logic [ROW_W-1:0]  h_ext;

    // Accept-stage decode
    logic             in_accept;
    logic             is_flush;
    logic             row_ge_h;
    logic             row_gt_h;
    logic             acc_final;
    logic             acc_proc;
    logic             acc_border;
    logic             acc_normal;
    logic             acc_emit;
    logic [WSZ_W-1:0] in_col_inc;
    logic [ROW_W-1:0] in_row_inc;
    logic [WSZ_W-1:0] out_col_inc;
    logic [ROW_W-1:0] out_row_inc;
    emit_info_t       acc_info;

    // Stage 1: line-store read data and grey value
    logic                  s1_shift_reg;
    logic                  s1_write_reg;
    logic                  s1_emit_reg;
    logic                  s1_flush_reg;
    logic [COL_W-1:0]      s1_col_reg;
    logic [GRAY_SUM_W-1:0] s1_sum_reg;
    emit_info_t            s1_info_reg;

    logic [RAM_W-1:0]       ram_rd_data;
    logic [RAM_W-1:0]       line_data;
    logic                   fwd_valid_reg;
    logic [COL_W-1:0]       fwd_addr_reg;
    logic [RAM_W-1:0]       fwd_data_reg;
    logic                   fwd_hit;
    logic [PIX_W-1:0]       line_top;
    logic [PIX_W-1:0]       line_mid;
    logic [PIX_W-1:0]       line_low;
    logic [GRAY_PROD_W-1:0] gray_prod;
    logic [PIX_W-1:0]       gray;

    // Stage 2: window and gradients
    logic [PIX_W-1:0] win_reg [9];
    logic             s2_emit_reg;
    emit_info_t       s2_info_reg;
    logic [PIX_W-1:0] lc [3];
    logic [PIX_W-1:0] cc [3];
    logic [PIX_W-1:0] rc [3];
    logic [PIX_W-1:0] lcol [3];
    logic [PIX_W-1:0] rcol [3];
    logic [PIX_W-1:0] l_t, l_m, l_b, c_t, c_b, r_t, r_m, r_b;
    logic [GRAD_W-1:0] gx_pos, gx_neg, gy_pos, gy_neg;
    logic [GRAD_W-1:0] gx_abs, gy_abs;

    // Stage 3 and 4
    logic              s3_emit_reg;
    logic              s3_last_reg;
    logic [GRAD_W-1:0] s3_gx_reg;
    logic [GRAD_W-1:0] s3_gy_reg;
    logic              s4_emit_reg;
    logic              s4_last_reg;
    logic [SQ_W-1:0]   s4_sqx_reg;
    logic [SQ_W-1:0]   s4_sqy_reg;
    logic [MAG_W-1:0]  mag;
    logic              is_edge;

    // Output buffer
    logic                  fifo_edge_reg [FIFO_DEPTH];
    logic                  fifo_last_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] fifo_wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] fifo_rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] fifo_count_reg;
    logic                  fifo_push;
    logic                  fifo_pop;
    logic [INFLIGHT_W-1:0] inflight;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg    <= FRAME_WIDTH_RESET;
            frame_height_reg   <= FRAME_HEIGHT_RESET;
            edge_threshold_reg <= EDGE_THRESHOLD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FRAME_WIDTH:    frame_width_reg    <= cfg_data;
                CFG_FRAME_HEIGHT:   frame_height_reg   <= cfg_data;
                CFG_EDGE_THRESHOLD: edge_threshold_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        thr_sq_reg <= THR_SQ_W'(edge_threshold_reg) * THR_SQ_W'(edge_threshold_reg);
    end

    always_comb
    begin
        fw_ext = WCMP_W'(frame_width_reg);
        fh_ext = HCMP_W'(frame_height_reg);
        if (fw_ext == '0)
        begin
            w_size = WSZ_W'(1);
        end
        else if (fw_ext > WCMP_W'(MAX_WIDTH))
        begin
            w_size = WSZ_W'(MAX_WIDTH);
        end
        else
        begin
            w_size = WSZ_W'(fw_ext);
        end
        if (fh_ext == '0)
        begin
            h_size = HSZ_W'(1);
        end
        else if (fh_ext > HCMP_W'(MAX_HEIGHT))
        begin
            h_size = HSZ_W'(MAX_HEIGHT);
        end
        else
        begin
            h_size = HSZ_W'(fh_ext);
        end
        h_ext = ROW_W'(h_size);
    end

    // ------------------------------------------------------------------
    // Accept stage
    // ------------------------------------------------------------------
    assign in_accept = in_valid && !in_stall;
    assign is_flush  = (cmd == CMD_FLUSH);
    assign row_ge_h  = (in_row_reg >= h_ext);
    assign row_gt_h  = (in_row_reg > h_ext);

    assign acc_final  = in_accept && is_flush && row_gt_h;
    assign acc_proc   = in_accept && (is_flush ? (row_ge_h && !row_gt_h) : !row_ge_h);
    assign acc_border = acc_proc && (in_column_reg == '0) && (in_row_reg >= ROW_W'(2));
    assign acc_normal = acc_proc && (in_column_reg != '0) && (in_row_reg != '0);
    assign acc_emit   = acc_final || acc_border || acc_normal;

    assign in_col_inc  = WSZ_W'(in_column_reg) + WSZ_W'(1);
    assign in_row_inc  = in_row_reg + ROW_W'(1);
    assign out_col_inc = WSZ_W'(out_column_reg) + WSZ_W'(1);
    assign out_row_inc = out_row_reg + ROW_W'(1);

    always_comb
    begin
        if (acc_final)
        begin
            acc_info.mode = EMIT_FINAL;
        end
        else if (acc_border)
        begin
            acc_info.mode = EMIT_BORDER;
        end
        else
        begin
            acc_info.mode = EMIT_NORMAL;
        end
        acc_info.left_centre   = (out_column_reg == '0);
        acc_info.right_centre  = (out_col_inc >= w_size);
        acc_info.top_centre    = (out_row_reg == '0);
        acc_info.bottom_centre = (out_row_inc >= h_ext);
        acc_info.last          = acc_final;
    end

    always_comb
    begin
        in_column_next  = in_column_reg;
        in_row_next     = in_row_reg;
        out_column_next = out_column_reg;
        out_row_next    = out_row_reg;
        if (acc_final)
        begin
            in_column_next  = '0;
            in_row_next     = '0;
            out_column_next = '0;
            out_row_next    = '0;
        end
        else if (acc_proc)
        begin
            if (in_col_inc >= w_size)
            begin
                in_column_next = '0;
                in_row_next    = in_row_inc;
            end
            else
            begin
                in_column_next = COL_W'(in_col_inc);
            end
            if (acc_border || acc_normal)
            begin
                if (out_col_inc >= w_size)
                begin
                    out_column_next = '0;
                    out_row_next    = out_row_inc;
                end
                else
                begin
                    out_column_next = COL_W'(out_col_inc);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_column_reg  <= '0;
            in_row_reg     <= '0;
            out_column_reg <= '0;
            out_row_reg    <= '0;
            s1_shift_reg   <= 1'b0;
            s1_write_reg   <= 1'b0;
            s1_emit_reg    <= 1'b0;
        end
        else
        begin
            in_column_reg  <= in_column_next;
            in_row_reg     <= in_row_next;
            out_column_reg <= out_column_next;
            out_row_reg    <= out_row_next;
            s1_shift_reg   <= acc_proc;
            s1_write_reg   <= acc_proc && !is_flush;
            s1_emit_reg    <= acc_emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_flush_reg <= is_flush;
            s1_col_reg   <= in_column_reg;
            s1_sum_reg   <= gray_weighted_sum(pixel_red, pixel_green, pixel_blue);
            s1_info_reg  <= acc_info;
        end
    end

    // ------------------------------------------------------------------
    // Line store: upper row in the high byte, middle row in the low byte
    // ------------------------------------------------------------------
    gset_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (s1_write_reg),
        .wr_addr (s1_col_reg),
        .wr_data ({line_mid, line_low}),
        .rd_addr (in_column_reg),
        .rd_data (ram_rd_data)
    );

    // A write in the cycle of the read is missed by the read; take it from here.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            fwd_valid_reg <= s1_write_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_addr_reg <= s1_col_reg;
        fwd_data_reg <= {line_mid, line_low};
    end

    assign fwd_hit   = fwd_valid_reg && (fwd_addr_reg == s1_col_reg);
    assign line_data = fwd_hit ? fwd_data_reg : ram_rd_data;
    assign line_top  = line_data[RAM_W-1:PIX_W];
    assign line_mid  = line_data[PIX_W-1:0];
    assign gray_prod = GRAY_PROD_W'(s1_sum_reg) * GRAY_RECIP;
    assign gray      = gray_prod[GRAY_SHIFT +: PIX_W];
    assign line_low  = s1_flush_reg ? line_mid : gray;

    // ------------------------------------------------------------------
    // Window: column 0 oldest, row 0 top
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= '0;
            end
            s2_emit_reg <= 1'b0;
        end
        else
        begin
            if (s1_shift_reg)
            begin
                for (int i = 0; i < 6; i++)
                begin
                    win_reg[i] <= win_reg[i + 3];
                end
                win_reg[6] <= line_top;
                win_reg[7] <= line_mid;
                win_reg[8] <= line_low;
            end
            s2_emit_reg <= s1_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_info_reg <= s1_info_reg;
    end

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            lc[j] = win_reg[j];
            cc[j] = win_reg[3 + j];
            rc[j] = win_reg[6 + j];
        end
        case (s2_info_reg.mode)
            EMIT_NORMAL:
            begin
                for (int j = 0; j < 3; j++)
                begin
                    lc[j] = win_reg[j];
                    cc[j] = win_reg[3 + j];
                    rc[j] = win_reg[6 + j];
                end
            end
            EMIT_BORDER:
            begin
                for (int j = 0; j < 3; j++)
                begin
                    lc[j] = win_reg[j];
                    cc[j] = win_reg[3 + j];
                    rc[j] = win_reg[3 + j];
                end
            end
            EMIT_FINAL:
            begin
                for (int j = 0; j < 3; j++)
                begin
                    lc[j] = win_reg[3 + j];
                    cc[j] = win_reg[6 + j];
                    rc[j] = win_reg[6 + j];
                end
            end
            default:
            begin
                for (int j = 0; j < 3; j++)
                begin
                    lc[j] = win_reg[j];
                    cc[j] = win_reg[3 + j];
                    rc[j] = win_reg[6 + j];
                end
            end
        endcase
        for (int j = 0; j < 3; j++)
        begin
            lcol[j] = s2_info_reg.left_centre ? cc[j] : lc[j];
            rcol[j] = s2_info_reg.right_centre ? cc[j] : rc[j];
        end
        l_t = s2_info_reg.top_centre ? lcol[1] : lcol[0];
        c_t = s2_info_reg.top_centre ? cc[1] : cc[0];
        r_t = s2_info_reg.top_centre ? rcol[1] : rcol[0];
        l_b = s2_info_reg.bottom_centre ? lcol[1] : lcol[2];
        c_b = s2_info_reg.bottom_centre ? cc[1] : cc[2];
        r_b = s2_info_reg.bottom_centre ? rcol[1] : rcol[2];
        l_m = lcol[1];
        r_m = rcol[1];

        gx_pos = GRAD_W'(r_t) + (GRAD_W'(r_m) << 1) + GRAD_W'(r_b);
        gx_neg = GRAD_W'(l_t) + (GRAD_W'(l_m) << 1) + GRAD_W'(l_b);
        gy_pos = GRAD_W'(l_b) + (GRAD_W'(c_b) << 1) + GRAD_W'(r_b);
        gy_neg = GRAD_W'(l_t) + (GRAD_W'(c_t) << 1) + GRAD_W'(r_t);
        gx_abs = (gx_pos >= gx_neg) ? (gx_pos - gx_neg) : (gx_neg - gx_pos);
        gy_abs = (gy_pos >= gy_neg) ? (gy_pos - gy_neg) : (gy_neg - gy_pos);
    end

    // ------------------------------------------------------------------
    // Squares and threshold
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_emit_reg <= 1'b0;
            s4_emit_reg <= 1'b0;
        end
        else
        begin
            s3_emit_reg <= s2_emit_reg;
            s4_emit_reg <= s3_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_last_reg <= s2_info_reg.last;
        s3_gx_reg   <= gx_abs;
        s3_gy_reg   <= gy_abs;
        s4_last_reg <= s3_last_reg;
        s4_sqx_reg  <= SQ_W'(s3_gx_reg) * SQ_W'(s3_gx_reg);
        s4_sqy_reg  <= SQ_W'(s3_gy_reg) * SQ_W'(s3_gy_reg);
    end

    assign mag     = MAG_W'(s4_sqx_reg) + MAG_W'(s4_sqy_reg);
    assign is_edge = (THR_SQ_W'(mag) >= thr_sq_reg);

    // ------------------------------------------------------------------
    // Output buffer
    // ------------------------------------------------------------------
    assign fifo_push = s4_emit_reg;
    assign fifo_pop  = out_valid && !out_stall;
    assign inflight  = INFLIGHT_W'(s1_emit_reg) + INFLIGHT_W'(s2_emit_reg)
                     + INFLIGHT_W'(s3_emit_reg) + INFLIGHT_W'(s4_emit_reg);
    assign in_stall  = (STALL_W'(fifo_count_reg) + STALL_W'(inflight))
                       >= STALL_W'(FIFO_DEPTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fifo_wr_ptr_reg <= '0;
            fifo_rd_ptr_reg <= '0;
            fifo_count_reg  <= '0;
        end
        else
        begin
            if (fifo_push)
            begin
                fifo_wr_ptr_reg <= fifo_wr_ptr_reg + FIFO_PTR_W'(1);
            end
            if (fifo_pop)
            begin
                fifo_rd_ptr_reg <= fifo_rd_ptr_reg + FIFO_PTR_W'(1);
            end
            case ({fifo_push, fifo_pop})
                2'b10:   fifo_count_reg <= fifo_count_reg + FIFO_CNT_W'(1);
                2'b01:   fifo_count_reg <= fifo_count_reg - FIFO_CNT_W'(1);
                default: fifo_count_reg <= fifo_count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (fifo_push)
        begin
            fifo_edge_reg[fifo_wr_ptr_reg] <= is_edge;
            fifo_last_reg[fifo_wr_ptr_reg] <= s4_last_reg;
        end
    end

    assign out_valid  = (fifo_count_reg != '0);
    assign edge_value = fifo_edge_reg[fifo_rd_ptr_reg] ? EDGE_ON : EDGE_OFF;
    assign frame_last = fifo_last_reg[fifo_rd_ptr_reg];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `GSET_ASSERT_IMP(a_buffer_no_overflow, fifo_push,
        fifo_count_reg != FIFO_CNT_W'(FIFO_DEPTH),
        "Output buffer written while full.")
    `GSET_ASSERT_IMP(a_result_has_cause, fifo_push, $past(acc_emit, 4),
        "Result word without an accepted word four cycles earlier.")
    `GSET_ASSERT_NXT(a_frame_restart, acc_final,
        in_row_reg == '0 && in_column_reg == '0 && out_row_reg == '0,
        "Counters not back at frame start after the final flush.")

endmodule

/* sim/edge_stream_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Edge stream checker
// Watches the configuration port and both word channels of the grey-scale
// Sobel edge unit. Every accepted input word advances a private copy of the
// line stores, window and counters, which queues the edge words that word
// must produce. Every accepted result word is compared with the oldest
// queued one, and the number of mismatches is handed to the top.
// ----------------------------------------------------------------------------
module edge_stream_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_stall,
    input  logic [gset_pkg::CMD_W-1:0]       cmd,
    input  logic [gset_pkg::PIX_W-1:0]       pixel_red,
    input  logic [gset_pkg::PIX_W-1:0]       pixel_green,
    input  logic [gset_pkg::PIX_W-1:0]       pixel_blue,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic [gset_pkg::PIX_W-1:0]       edge_value,
    input  logic                             frame_last,
    input  logic                             cfg_we,
    input  logic [gset_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gset_pkg::CFG_W-1:0]       cfg_data,
    output int                               mismatches,
    output int                               results_pending
);
    import gset_pkg::*;

    localparam int REPORT_LIMIT = 30;

    typedef struct packed {
        logic [PIX_W-1:0] edge_value;
        logic             frame_last;
    } edge_word_t;

    edge_word_t       edges_due [$];
    logic [PIX_W-1:0] upper_row [MAX_WIDTH_DEFAULT];
    logic [PIX_W-1:0] middle_row [MAX_WIDTH_DEFAULT];
    int               window [9];
    int unsigned      in_col;
    int unsigned      in_row;
    int unsigned      out_col;
    int unsigned      out_row;
    logic [CFG_W-1:0] width_setting;
    logic [CFG_W-1:0] height_setting;
    logic [CFG_W-1:0] threshold_setting;

    function automatic int unsigned size_in_use(input logic [CFG_W-1:0] setting,
                                                input int unsigned limit);
        if (setting == 0)
            return 1;
        if (setting > limit)
            return limit;
        return setting;
    endfunction

    // Window columns start at 0 (oldest), 3 and 6; rows are offsets 0 to 2.
    task automatic compute_edge(input int lc, input int cc, input int rc,
                                input int unsigned w, input int unsigned h,
                                input logic last);
        int         lo;
        int         ro;
        int         t;
        int         b;
        int         gx;
        int         gy;
        edge_word_t word;
        lo = (out_col == 0) ? cc : lc;
        ro = (out_col + 1 >= w) ? cc : rc;
        t  = (out_row == 0) ? 1 : 0;
        b  = (out_row + 1 >= h) ? 1 : 2;
        gx = (window[ro + t] + 2 * window[ro + 1] + window[ro + b])
           - (window[lo + t] + 2 * window[lo + 1] + window[lo + b]);
        gy = (window[lo + b] + 2 * window[cc + b] + window[ro + b])
           - (window[lo + t] + 2 * window[cc + t] + window[ro + t]);
        word.edge_value = (gx * gx + gy * gy >= int'(threshold_setting) * int'(threshold_setting))
                        ? EDGE_ON : EDGE_OFF;
        word.frame_last = last;
        edges_due.push_back(word);
        out_col++;
        if (out_col >= w)
        begin
            out_col = 0;
            out_row++;
        end
    endtask

    task automatic slide_window(input logic flush, input logic [PIX_W-1:0] red,
                                input logic [PIX_W-1:0] green, input logic [PIX_W-1:0] blue);
        int unsigned w;
        int unsigned h;
        int unsigned col;
        int          top;
        int          mid;
        int          low;
        int          i;
        w = size_in_use(width_setting, MAX_WIDTH_DEFAULT);
        h = size_in_use(height_setting, MAX_HEIGHT_DEFAULT);
        if (!flush && in_row >= h)
            return;
        if (flush && in_row < h)
            return;
        if (flush && in_row > h)
        begin
            compute_edge(3, 6, 6, w, h, 1'b1);
            in_col  = 0;
            in_row  = 0;
            out_col = 0;
            out_row = 0;
            return;
        end
        if (in_col == 0 && in_row >= 2)
            compute_edge(3, 6, 6, w, h, 1'b0);
        col = (in_col < MAX_WIDTH_DEFAULT) ? in_col : MAX_WIDTH_DEFAULT - 1;
        top = upper_row[col];
        mid = middle_row[col];
        if (flush)
            low = mid;
        else
        begin
            low = (299 * red + 587 * green + 114 * blue) / 1000;
            upper_row[col]  = PIX_W'(mid);
            middle_row[col] = PIX_W'(low);
        end
        for (i = 0; i < 6; i++)
            window[i] = window[i + 3];
        window[6] = top;
        window[7] = mid;
        window[8] = low;
        if (in_col >= 1 && in_row >= 1)
            compute_edge(0, 3, 6, w, h, 1'b0);
        in_col++;
        if (in_col >= w)
        begin
            in_col = 0;
            in_row++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edges_due.delete();
            foreach (upper_row[i])
                upper_row[i] = '0;
            foreach (middle_row[i])
                middle_row[i] = '0;
            foreach (window[i])
                window[i] = 0;
            in_col            = 0;
            in_row            = 0;
            out_col           = 0;
            out_row           = 0;
            width_setting     = FRAME_WIDTH_RESET;
            height_setting    = FRAME_HEIGHT_RESET;
            threshold_setting = EDGE_THRESHOLD_RESET;
            mismatches        = 0;
            results_pending   = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (edges_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: edge word %0d (frame_last %0d) arrived, none expected",
                                 $time, edge_value, frame_last);
                end
                else
                begin
                    edge_word_t due;
                    due = edges_due.pop_front();
                    if (edge_value !== due.edge_value)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("%0t: edge_value expected %0d, got %0d",
                                     $time, due.edge_value, edge_value);
                    end
                    if (frame_last !== due.frame_last)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("%0t: frame_last expected %0d, got %0d",
                                     $time, due.frame_last, frame_last);
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FRAME_WIDTH:    width_setting = cfg_data;
                    CFG_FRAME_HEIGHT:   height_setting = cfg_data;
                    CFG_EDGE_THRESHOLD: threshold_setting = cfg_data;
                    default:            ;
                endcase
            end
            if (in_valid && !in_stall)
                slide_window(cmd == CMD_FLUSH, pixel_red, pixel_green, pixel_blue);
            results_pending = edges_due.size();
        end
    end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the grey-scale Sobel edge unit
// Writes frame sizes and thresholds while the unit is idle, then streams
// frames of pixel words followed by their draining flush words, with stray
// flushes and surplus pixels mixed in. Both channels idle at random, the
// receiver once holds off long enough to fill the unit, and the checker
// beside the unit predicts and compares every result word.
// ----------------------------------------------------------------------------
module testbench;
    import gset_pkg::*;

    localparam int ITEM_TARGET    = 900;
    localparam int LONG_HOLD      = 300;
    localparam int SETTLE_CYCLES  = 12;
    localparam int WATCHDOG_LIMIT = 3000;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [CMD_W-1:0]     cmd = CMD_PIXEL;
    logic [PIX_W-1:0]     pixel_red = '0;
    logic [PIX_W-1:0]     pixel_green = '0;
    logic [PIX_W-1:0]     pixel_blue = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [PIX_W-1:0]     edge_value;
    logic                 frame_last;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_FRAME_WIDTH;
    logic [CFG_W-1:0]     cfg_data = '0;
    int                   mismatches;
    int                   results_pending;
    int                   sender_mode = 0;
    int                   frame_words = 0;
    bit                   long_hold_due = 1'b0;

    gray_sobel_edge_threshold_unit DUT (.*);

    edge_stream_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int idle_draw(input int mode);
        case (mode)
            0:       return 0;
            1:       return $urandom_range(0, 13);
            default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
        endcase
    endfunction

    function automatic int effective_size(input int setting, input int limit);
        if (setting == 0)
            return 1;
        if (setting > limit)
            return limit;
        return setting;
    endfunction

    function automatic logic [23:0] draw_pixel(input int style, input int col, input int row);
        logic [7:0] level;
        case (style)
            0: return 24'($urandom);
            1:
            begin
                level = 8'(col * 9 + row * 13);
                return {level + 8'($urandom_range(0, 7)), level, level - 8'($urandom_range(0, 7))};
            end
            2:
            begin
                level = (((col / 3) + (row / 2)) % 2 == 1) ? 8'd230 : 8'd20;
                return {level, level, level};
            end
            default:
                return {($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00,
                        ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00,
                        ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00};
        endcase
    endfunction

    task automatic write_register(input logic [CFG_IDX_W-1:0] index, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= CFG_W'(value);
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_frame(input int width_value, input int height_value, input int threshold);
        write_register(CFG_FRAME_WIDTH, width_value);
        write_register(CFG_FRAME_HEIGHT, height_value);
        write_register(CFG_EDGE_THRESHOLD, threshold);
    endtask

    task automatic send_word(input logic [CMD_W-1:0] kind, input logic [23:0] rgb);
        int wait_cycles;
        wait_cycles = idle_draw(sender_mode);
        if (wait_cycles > 0)
        begin
            in_valid <= 1'b0;
            repeat (wait_cycles) @(negedge clk);
        end
        cmd <= kind;
        {pixel_red, pixel_green, pixel_blue} <= rgb;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (results_pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic send_frame(input int w, input int h, input int style,
                              input bit noisy, input bit pause_mid);
        int row;
        int col;
        int n;
        for (row = 0; row < h; row++)
        begin
            if (pause_mid && row > 0 && row == h / 2)
                settle();
            for (col = 0; col < w; col++)
            begin
                if (noisy && $urandom_range(0, 15) == 0)
                    send_word(CMD_FLUSH, 24'($urandom));
                send_word(CMD_PIXEL, draw_pixel(style, col, row));
            end
        end
        if (noisy)
            repeat ($urandom_range(1, 2)) send_word(CMD_PIXEL, 24'($urandom));
        for (n = 0; n <= w; n++)
        begin
            send_word(CMD_FLUSH, 24'($urandom));
            if (noisy && n < w && $urandom_range(0, 7) == 0)
                send_word(CMD_PIXEL, 24'($urandom));
        end
        if (noisy)
            send_word(CMD_FLUSH, 24'($urandom));
        frame_words += w * h + w + 1;
    endtask

    initial
    begin : receiver
        int stall_cycles;
        int taken;
        int recv_mode;
        taken     = 0;
        recv_mode = 0;
        @(negedge clk);
        forever
        begin
            if (taken % 48 == 0)
                recv_mode = $urandom_range(0, 2);
            stall_cycles = idle_draw(recv_mode);
            if (long_hold_due)
            begin
                stall_cycles += LONG_HOLD;
                long_hold_due = 1'b0;
            end
            if (stall_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (stall_cycles) @(negedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            @(negedge clk);
            taken++;
        end
    end

    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("testbench NOT OK");
        $finish;
    end

    initial
    begin : stimulus
        logic [23:0] corner_rgb [9];
        int          i;
        int          frame_no;
        int          w_set;
        int          h_set;
        int          threshold;
        corner_rgb = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
                       24'hFFFFFF, 24'h000000, 24'h804020, 24'hFFFFFF};
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // A 3 x 3 frame with extreme colours, a flush before the last
        // pixel, a pixel after it and a flush once the frame has drained.
        set_frame(3, 3, 200);
        for (i = 0; i < 8; i++)
            send_word(CMD_PIXEL, corner_rgb[i]);
        send_word(CMD_FLUSH, 24'hFFFFFF);
        send_word(CMD_PIXEL, corner_rgb[8]);
        send_word(CMD_PIXEL, 24'h123456);
        for (i = 0; i < 4; i++)
            send_word(CMD_FLUSH, 24'(i));
        send_word(CMD_FLUSH, 24'h000000);
        settle();

        // Zero sizes are used as a single pixel.
        set_frame(0, 0, 0);
        send_word(CMD_PIXEL, 24'hA5C3E1);
        send_word(CMD_PIXEL, 24'h5A3C1E);
        send_word(CMD_FLUSH, 24'hFFFFFF);
        send_word(CMD_FLUSH, 24'h000000);
        settle();

        frame_no = 0;
        while (frame_words < ITEM_TARGET)
        begin
            w_set = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 24);
            h_set = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 8);
            case (frame_no)
                0:       threshold = 0;
                1:       threshold = 1443;
                2:       threshold = 2047;
                default: threshold = $urandom_range(0, 600);
            endcase
            sender_mode = $urandom_range(0, 2);
            if (frame_no == 3)
            begin
                w_set         = 20;
                h_set         = 8;
                sender_mode   = 0;
                long_hold_due = 1'b1;
            end
            set_frame(w_set, h_set, threshold);
            send_frame(effective_size(w_set, MAX_WIDTH_DEFAULT),
                       effective_size(h_set, MAX_HEIGHT_DEFAULT),
                       $urandom_range(0, 3),
                       frame_no != 3 && $urandom_range(0, 2) == 0,
                       frame_no == 4 || $urandom_range(0, 9) == 0);
            settle();
            frame_no++;
        end

        // Oversized settings are used as the largest frame dimensions.
        sender_mode = $urandom_range(0, 2);
        set_frame(2047, 0, $urandom_range(50, 400));
        send_frame(MAX_WIDTH_DEFAULT, 1, $urandom_range(0, 3), 1'b1, 1'b0);
        settle();
        sender_mode = $urandom_range(0, 2);
        set_frame(1, 2047, $urandom_range(0, 300));
        send_frame(1, MAX_HEIGHT_DEFAULT, $urandom_range(0, 3), 1'b1, 1'b1);
        settle();

        if (mismatches == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

/* gray_sobel_edge_threshold_unit.f */
+incdir+hdl
hdl/gset_pkg.sv
hdl/gset_ram.sv
hdl/gray_sobel_edge_threshold_unit.sv
sim/edge_stream_checker.sv
sim/testbench.sv
